[hdl/dqne_pkg.sv]
// Shared types and constants for the DNS query name expander.
package dqne_pkg;

  localparam int HEADER_BYTES = 12;
  localparam int QC_HI_POS    = 4;
  localparam int QC_LO_POS    = 5;
  localparam int PTR_W        = 14;

  localparam logic [1:0] TYPE_LABEL = 2'b00;
  localparam logic [1:0] TYPE_PTR   = 2'b11;

  localparam logic [7:0] DOT_CHAR  = 8'h2e;
  localparam logic [7:0] BACKSLASH = 8'h5c;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_QCOUNT    = 3'd1;
  localparam logic [2:0] ST_MALFORMED = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_SHORT     = 3'd4;
  localparam logic [2:0] ST_OVERFLOW  = 3'd5;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [63:0] name_chunk;
    logic [3:0]  chunk_bytes;
    logic [2:0]  status;
    logic        last_chunk;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic check;
    logic lbl_rd;
    logic lbl_ev;
    logic ptr_rd;
    logic ptr_ev;
    logic ch_rd;
    logic ch_ev;
    logic esc;
    logic fin;
    logic nm_cap;
    logic emit_ok;
    logic emit_err;
    logic clr;
  } cmd_t;

  typedef struct packed {
    logic last_acc;
    logic err;
    logic name_end;
    logic is_ptr;
    logic is_dot;
    logic lbl_done;
    logic chunk_full;
    logic final_chunk;
    logic slot_free;
  } sts_t;

endpackage

[hdl/dns_query_name_expander.sv]
// Top level of the DNS query name expander.
// Usage: the message is pushed on the in_ channel one byte per word, header first,
// with last_byte set on the final byte; the input is not stalled between bytes.
// After the last byte the block stalls its input, checks the header and walks the
// first question name from offset 12. Each label, pointer or character byte is
// read from the message buffer and evaluated; an escaped dot adds an escape step.
// The dotted name then leaves on the out_ channel in words of up to eight
// characters, each read from the name buffer and captured before the word leaves;
// an error gives a single word with its status and last_chunk set.
// The result register lets the next message load while the final word waits.
// When the receiver stalls, the word holds; a following word waits for it and the
// input stays stalled meanwhile.
// cfg_wr_en/cfg_wr_data write the one-question check enable (set after reset).
// Reset clears the length count, overflow flag and output valid; the buffers need
// no clearing, so the block takes bytes as soon as reset is released.
module dns_query_name_expander
  import dqne_pkg::*;
#(
  parameter int MAX_MESSAGE = 512,
  parameter int MAX_NAME    = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);

  cmd_t cmd;
  sts_t sts;

  assign in_stall = !cmd.load || !rst_n;

  dqne_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  dqne_dp #(
    .MAX_MESSAGE (MAX_MESSAGE),
    .MAX_NAME    (MAX_NAME)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_valid    (in_valid),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

  a_load_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_data.last_byte) |=> !in_stall)
    else $error("input stalled after a non-final byte");

  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.last_byte) |=> in_stall)
    else $error("input not stalled after final byte");

  a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |->
      (out_data.last_chunk && out_data.chunk_bytes == 4'd0))
    else $error("error word not final or not empty");

  a_full_chunk: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_OK && !out_data.last_chunk) |->
      (out_data.chunk_bytes == 4'd8))
    else $error("non-final name word not full");

endmodule

[hdl/dqne_ram.sv]
// Generic simple dual-port RAM with registered read.
module dqne_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/dqne_ctrl.sv]
// Sequencer for loading, name walk and chunked read-out.
module dqne_ctrl
  import dqne_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [13:0] {
    S_LOAD   = 14'b00000000000001,
    S_CHECK  = 14'b00000000000010,
    S_LBL_RD = 14'b00000000000100,
    S_LBL_EV = 14'b00000000001000,
    S_PTR_RD = 14'b00000000010000,
    S_PTR_EV = 14'b00000000100000,
    S_CH_RD  = 14'b00000001000000,
    S_CH_EV  = 14'b00000010000000,
    S_ESC    = 14'b00000100000000,
    S_FIN    = 14'b00001000000000,
    S_NM_RD  = 14'b00010000000000,
    S_NM_CAP = 14'b00100000000000,
    S_EMIT   = 14'b01000000000000,
    S_ERR    = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD: begin
        if (sts.last_acc) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = sts.err ? S_ERR : S_LBL_RD;
      end
      S_LBL_RD: begin
        state_nxt = sts.err ? S_ERR : S_LBL_EV;
      end
      S_LBL_EV: begin
        if (sts.err) state_nxt = S_ERR;
        else if (sts.name_end) state_nxt = S_FIN;
        else if (sts.is_ptr) state_nxt = S_PTR_RD;
        else state_nxt = S_CH_RD;
      end
      S_PTR_RD: begin
        state_nxt = sts.err ? S_ERR : S_PTR_EV;
      end
      S_PTR_EV: begin
        state_nxt = sts.err ? S_ERR : S_LBL_RD;
      end
      S_CH_RD: begin
        state_nxt = sts.err ? S_ERR : S_CH_EV;
      end
      S_CH_EV: begin
        if (sts.err) state_nxt = S_ERR;
        else if (sts.is_dot) state_nxt = S_ESC;
        else if (sts.lbl_done) state_nxt = S_LBL_RD;
        else state_nxt = S_CH_RD;
      end
      S_ESC: begin
        if (sts.err) state_nxt = S_ERR;
        else if (sts.lbl_done) state_nxt = S_LBL_RD;
        else state_nxt = S_CH_RD;
      end
      S_FIN: begin
        state_nxt = sts.err ? S_ERR : S_NM_RD;
      end
      S_NM_RD: begin
        state_nxt = S_NM_CAP;
      end
      S_NM_CAP: begin
        state_nxt = sts.chunk_full ? S_EMIT : S_NM_RD;
      end
      S_EMIT: begin
        if (sts.slot_free) state_nxt = sts.final_chunk ? S_LOAD : S_NM_RD;
      end
      S_ERR: begin
        if (sts.slot_free) state_nxt = S_LOAD;
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == S_LOAD);
    cmd.check    = (state_r == S_CHECK);
    cmd.lbl_rd   = (state_r == S_LBL_RD);
    cmd.lbl_ev   = (state_r == S_LBL_EV);
    cmd.ptr_rd   = (state_r == S_PTR_RD);
    cmd.ptr_ev   = (state_r == S_PTR_EV);
    cmd.ch_rd    = (state_r == S_CH_RD);
    cmd.ch_ev    = (state_r == S_CH_EV);
    cmd.esc      = (state_r == S_ESC);
    cmd.fin      = (state_r == S_FIN);
    cmd.nm_cap   = (state_r == S_NM_CAP);
    cmd.emit_ok  = (state_r == S_EMIT);
    cmd.emit_err = (state_r == S_ERR);
    cmd.clr      = sts.slot_free &&
                   ((state_r == S_ERR) || (state_r == S_EMIT && sts.final_chunk));
  end

endmodule

[hdl/dqne_dp.sv]
// Datapath: message buffer, name walk registers, name buffer and result register.
module dqne_dp
  import dqne_pkg::*;
#(
  parameter int MAX_MESSAGE = 512,
  parameter int MAX_NAME    = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  output sts_t      sts,
  input  logic      in_valid,
  input  in_word_t  in_data,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  input  logic      out_stall,
  output logic      out_valid,
  output out_word_t out_data
);

  localparam int LEN_W  = $clog2(MAX_MESSAGE + 1);
  localparam int ADDR_W = $clog2(MAX_MESSAGE);
  localparam int NAME_W = $clog2(MAX_NAME);
  localparam int NW1    = NAME_W + 1;
  localparam int DW     = ((NAME_W > 6) ? NAME_W : 6) + 2;
  localparam int CW     = (LEN_W > NAME_W) ? LEN_W : NAME_W;
  localparam int SW     = LEN_W + 7;

  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              ovf_r, ovf_nxt;
  logic              req_r, req_nxt;
  logic              qhi0_r, qhi0_nxt;
  logic              qlo1_r, qlo1_nxt;
  logic [LEN_W-1:0]  cp_r, cp_nxt;
  logic [LEN_W-1:0]  chk_r, chk_nxt;
  logic [NAME_W-1:0] d_r, d_nxt;
  logic [5:0]        n_r, n_nxt;
  logic [5:0]        hi_r, hi_nxt;
  logic              zseen_r, zseen_nxt;
  logic [NAME_W-1:0] zpos_r, zpos_nxt;
  logic [NAME_W-1:0] k_r, k_nxt;
  logic [2:0]        i_r, i_nxt;
  logic [NAME_W-1:0] total_r, total_nxt;
  logic [63:0]       chunk_r, chunk_nxt;
  logic [2:0]        err_r, err_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_r, out_nxt;

  logic [7:0]        msg_q, name_q;
  logic              acc, cp_end, is_zero, is_lbl, is_ptr, is_dot, d_nz;
  logic              lbl_ovf, dot_ovf, tgt_bad, chk_bad, end_hit, full, slot_free;
  logic [6:0]        chk_inc;
  logic [SW-1:0]     chk_sum;
  logic [LEN_W-1:0]  chk_sat;
  logic [PTR_W-1:0]  target;
  logic [NAME_W-1:0] nl, total_calc, nm_addr;
  logic              err;
  logic [2:0]        code;
  logic              nm_we;
  logic [7:0]        nm_wdata;

  assign acc       = in_valid && cmd.load;
  assign slot_free = !out_valid_r || !out_stall;

  dqne_ram #(.WIDTH(8), .DEPTH(MAX_MESSAGE)) u_msg_ram (
    .clk     (clk),
    .wr_en   (acc && (len_r < LEN_W'(MAX_MESSAGE))),
    .wr_addr (len_r[ADDR_W-1:0]),
    .wr_data (in_data.msg_byte),
    .rd_addr (cp_r[ADDR_W-1:0]),
    .rd_data (msg_q)
  );

  dqne_ram #(.WIDTH(8), .DEPTH(MAX_NAME)) u_name_ram (
    .clk     (clk),
    .wr_en   (nm_we),
    .wr_addr (d_r),
    .wr_data (nm_wdata),
    .rd_addr (nm_addr),
    .rd_data (name_q)
  );

  // decode of the fetched byte
  assign cp_end  = (cp_r >= len_r);
  assign is_zero = (msg_q == 8'h00);
  assign is_lbl  = (msg_q[7:6] == TYPE_LABEL) && !is_zero;
  assign is_ptr  = (msg_q[7:6] == TYPE_PTR);
  assign is_dot  = (msg_q == DOT_CHAR);
  assign d_nz    = (d_r != '0);
  assign lbl_ovf = (DW'(d_r) + DW'(d_nz) + DW'(msg_q[5:0])) >= DW'(MAX_NAME);
  assign dot_ovf = (DW'(d_r) + DW'(n_r) + DW'(2)) >= DW'(MAX_NAME);

  // running byte count for loop detection, saturating
  assign chk_inc = cmd.ptr_ev ? 7'd2 : ({1'b0, msg_q[5:0]} + 7'd1);
  assign chk_sum = SW'(chk_r) + SW'(chk_inc);
  assign chk_sat = (chk_sum >= SW'(MAX_MESSAGE)) ? LEN_W'(MAX_MESSAGE) : chk_sum[LEN_W-1:0];
  assign chk_bad = (chk_sat >= len_r);

  assign target  = {hi_r, msg_q};
  assign tgt_bad = (target >= PTR_W'(len_r));

  assign nl         = zseen_r ? zpos_r : d_r;
  assign total_calc = (CW'(nl) < CW'(len_r)) ? nl : NAME_W'(len_r);
  assign nm_addr    = k_r + NAME_W'(i_r);
  assign end_hit    = (NW1'(nm_addr) + NW1'(1)) >= NW1'(total_r);
  assign full       = (i_r == 3'd7) || end_hit;

  assign nm_we    = (cmd.lbl_ev && is_lbl && d_nz) || cmd.ch_ev || cmd.esc;
  assign nm_wdata = cmd.ch_ev ? (is_dot ? BACKSLASH : msg_q) : DOT_CHAR;

  always_comb begin
    err  = 1'b0;
    code = ST_MALFORMED;
    if (cmd.check) begin
      if (ovf_r) begin
        err  = 1'b1;
        code = ST_OVERFLOW;
      end else if (len_r < LEN_W'(HEADER_BYTES)) begin
        err  = 1'b1;
        code = ST_SHORT;
      end else if (req_r && !(qhi0_r && qlo1_r)) begin
        err  = 1'b1;
        code = ST_QCOUNT;
      end
    end
    if ((cmd.lbl_rd || cmd.ptr_rd || cmd.ch_rd || cmd.esc) && cp_end) begin
      err = 1'b1;
    end
    if (cmd.lbl_ev) begin
      if (is_lbl && lbl_ovf) begin
        err  = 1'b1;
        code = ST_OVERFLOW;
      end else if (!is_zero && !is_lbl && !is_ptr) begin
        err = 1'b1;
      end
    end
    if (cmd.ptr_ev && (tgt_bad || chk_bad)) begin
      err = 1'b1;
    end
    if (cmd.ch_ev) begin
      if (is_dot) begin
        if (dot_ovf) begin
          err  = 1'b1;
          code = ST_OVERFLOW;
        end
      end else if (cp_end) begin
        err = 1'b1;
      end
    end
    if (cmd.fin && (nl == '0)) begin
      err  = 1'b1;
      code = ST_EMPTY;
    end
  end

  always_comb begin
    len_nxt       = len_r;
    ovf_nxt       = ovf_r;
    req_nxt       = req_r;
    qhi0_nxt      = qhi0_r;
    qlo1_nxt      = qlo1_r;
    cp_nxt        = cp_r;
    chk_nxt       = chk_r;
    d_nxt         = d_r;
    n_nxt         = n_r;
    hi_nxt        = hi_r;
    zseen_nxt     = zseen_r;
    zpos_nxt      = zpos_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    total_nxt     = total_r;
    chunk_nxt     = chunk_r;
    err_nxt       = err ? code : err_r;
    out_nxt       = out_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;

    if (cfg_wr_en) req_nxt = cfg_wr_data;

    if (acc) begin
      if (len_r < LEN_W'(MAX_MESSAGE)) begin
        len_nxt = len_r + LEN_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
      if (len_r == LEN_W'(QC_HI_POS)) qhi0_nxt = (in_data.msg_byte == 8'h00);
      if (len_r == LEN_W'(QC_LO_POS)) qlo1_nxt = (in_data.msg_byte == 8'h01);
    end

    if (cmd.clr) begin
      len_nxt = '0;
      ovf_nxt = 1'b0;
    end

    if (cmd.check) begin
      cp_nxt    = LEN_W'(HEADER_BYTES);
      chk_nxt   = '0;
      d_nxt     = '0;
      zseen_nxt = 1'b0;
    end

    if (cmd.lbl_rd || cmd.ptr_rd) cp_nxt = cp_r + LEN_W'(1);

    if (cmd.lbl_ev) begin
      if (is_lbl) begin
        d_nxt   = d_r + NAME_W'(d_nz);
        n_nxt   = msg_q[5:0];
        chk_nxt = chk_sat;
      end else begin
        hi_nxt = msg_q[5:0];
      end
    end

    if (cmd.ptr_ev) begin
      cp_nxt  = LEN_W'(target);
      chk_nxt = chk_sat;
    end

    if (cmd.ch_rd) begin
      cp_nxt = cp_r + LEN_W'(1);
      n_nxt  = n_r - 6'd1;
    end

    if (cmd.ch_ev) begin
      d_nxt = d_r + NAME_W'(1);
      if (is_zero && !zseen_r) begin
        zseen_nxt = 1'b1;
        zpos_nxt  = d_r;
      end
    end

    if (cmd.esc) d_nxt = d_r + NAME_W'(1);

    if (cmd.fin) begin
      total_nxt = total_calc;
      k_nxt     = '0;
      i_nxt     = '0;
    end

    if (cmd.nm_cap) begin
      if (i_r == 3'd0) chunk_nxt = '0;
      chunk_nxt[{i_r, 3'b000} +: 8] = name_q;
      if (!full) i_nxt = i_r + 3'd1;
    end

    if (cmd.emit_ok && slot_free) begin
      out_nxt.name_chunk  = chunk_r;
      out_nxt.chunk_bytes = {1'b0, i_r} + 4'd1;
      out_nxt.status      = ST_OK;
      out_nxt.last_chunk  = end_hit;
      out_valid_nxt       = 1'b1;
      k_nxt               = k_r + NAME_W'(8);
      i_nxt               = '0;
    end

    if (cmd.emit_err && slot_free) begin
      out_nxt.name_chunk  = '0;
      out_nxt.chunk_bytes = '0;
      out_nxt.status      = err_r;
      out_nxt.last_chunk  = 1'b1;
      out_valid_nxt       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      ovf_r       <= 1'b0;
      req_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      req_r       <= req_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    qhi0_r  <= qhi0_nxt;
    qlo1_r  <= qlo1_nxt;
    cp_r    <= cp_nxt;
    chk_r   <= chk_nxt;
    d_r     <= d_nxt;
    n_r     <= n_nxt;
    hi_r    <= hi_nxt;
    zseen_r <= zseen_nxt;
    zpos_r  <= zpos_nxt;
    k_r     <= k_nxt;
    i_r     <= i_nxt;
    total_r <= total_nxt;
    chunk_r <= chunk_nxt;
    err_r   <= err_nxt;
    out_r   <= out_nxt;
  end

  always_comb begin
    sts             = '0;
    sts.last_acc    = acc && in_data.last_byte;
    sts.err         = err;
    sts.name_end    = is_zero;
    sts.is_ptr      = is_ptr;
    sts.is_dot      = is_dot;
    sts.lbl_done    = (n_r == 6'd0);
    sts.chunk_full  = full;
    sts.final_chunk = end_hit;
    sts.slot_free   = slot_free;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[test/tb_dns_query_name_expander.sv]
`timescale 1ns / 100ps
// Testbench for the DNS query name expander: directed and random messages checked by a scoreboard.
module tb_dns_query_name_expander
  import dqne_pkg::*;
();

  localparam int MSG_CAP     = 512;
  localparam int NAME_CAP    = 256;
  localparam int PTR_HI_MASK = 'h3f;
  localparam int IDLE_LIMIT  = 20000;
  localparam int SETTLE      = 40;
  localparam int LONG_HOLD   = 400;

  typedef byte unsigned bytes_t[$];

  class qname_board;
    byte unsigned msg_mem [MSG_CAP];
    byte unsigned name_mem [NAME_CAP];
    int           msg_len;
    bit           msg_ovf;
    int           qname_len;
    bit           one_question = 1'b1;
    out_word_t    chunks_due [$];
    int           mismatches;

    function bit fetch(int pos, int len, output int v);
      v = 0;
      if (pos >= len || pos >= MSG_CAP) return 1'b0;
      v = msg_mem[pos];
      return 1'b1;
    endfunction

    function void put_char(inout int d, input int c);
      if (d < NAME_CAP) name_mem[d] = c;
      d++;
    endfunction

    function logic [2:0] expand_qname(int len);
      int cp, d, checked, n, c, low, target, i;
      cp = HEADER_BYTES;
      d = 0;
      checked = 0;
      forever begin
        if (!fetch(cp, len, n)) return ST_MALFORMED;
        cp++;
        if (n == 0) break;
        if (n[7:6] == TYPE_LABEL) begin
          if (d != 0) begin
            if (d >= NAME_CAP) return ST_OVERFLOW;
            put_char(d, DOT_CHAR);
          end
          if (d + n >= NAME_CAP) return ST_OVERFLOW;
          checked += n + 1;
          while (n > 0) begin
            n--;
            if (!fetch(cp, len, c)) return ST_MALFORMED;
            cp++;
            if (c == DOT_CHAR) begin
              if (d + n + 2 >= NAME_CAP) return ST_OVERFLOW;
              put_char(d, BACKSLASH);
            end
            put_char(d, c);
            if (cp >= len) return ST_MALFORMED;
          end
        end else if (n[7:6] == TYPE_PTR) begin
          if (!fetch(cp, len, low)) return ST_MALFORMED;
          target = ((n & PTR_HI_MASK) << 8) | low;
          if (target >= len) return ST_MALFORMED;
          cp = target;
          checked += 2;
          if (checked >= len) return ST_MALFORMED;
        end else begin
          return ST_MALFORMED;
        end
      end
      if (d > NAME_CAP) d = NAME_CAP;
      qname_len = d;
      for (i = 0; i < d; i++) begin
        if (name_mem[i] == 0) begin
          qname_len = i;
          break;
        end
      end
      return ST_OK;
    endfunction

    function void close_message();
      int len, total, k, i, cnt;
      logic [2:0] st;
      out_word_t w;
      len = msg_len;
      if (msg_ovf) st = ST_OVERFLOW;
      else if (len < HEADER_BYTES) st = ST_SHORT;
      else if (one_question && {msg_mem[QC_HI_POS], msg_mem[QC_LO_POS]} != 16'd1) st = ST_QCOUNT;
      else begin
        qname_len = 0;
        st = expand_qname(len);
        if (st == ST_OK && qname_len == 0) st = ST_EMPTY;
      end
      if (st != ST_OK) begin
        w = '0;
        w.status = st;
        w.last_chunk = 1'b1;
        chunks_due.push_back(w);
        return;
      end
      total = (qname_len < len) ? qname_len : len;
      for (k = 0; k < total; k += 8) begin
        cnt = (total - k < 8) ? total - k : 8;
        w = '0;
        for (i = 0; i < cnt; i++) w.name_chunk[8*i +: 8] = name_mem[(k + i) % NAME_CAP];
        w.chunk_bytes = cnt;
        w.status = ST_OK;
        w.last_chunk = (k + cnt >= total);
        chunks_due.push_back(w);
      end
    endfunction

    function void take_word(in_word_t w);
      if (msg_len < MSG_CAP) begin
        msg_mem[msg_len] = w.msg_byte;
        msg_len++;
      end else begin
        msg_ovf = 1'b1;
      end
      if (w.last_byte) begin
        close_message();
        msg_len = 0;
        msg_ovf = 1'b0;
      end
    endfunction

    function void match_chunk(out_word_t got);
      out_word_t want;
      if (chunks_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: %h/%0d/%0d/%0b", got.name_chunk, got.chunk_bytes,
                   got.status, got.last_chunk);
        return;
      end
      want = chunks_due.pop_front();
      if (got.name_chunk !== want.name_chunk || got.chunk_bytes !== want.chunk_bytes ||
          got.status !== want.status || got.last_chunk !== want.last_chunk) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word mismatch: expected %h/%0d/%0d/%0b got %h/%0d/%0d/%0b",
                   want.name_chunk, want.chunk_bytes, want.status, want.last_chunk,
                   got.name_chunk, got.chunk_bytes, got.status, got.last_chunk);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n       = 1'b0;
  logic      in_valid    = 1'b0;
  logic      in_stall;
  in_word_t  in_data     = '0;
  logic      out_valid;
  logic      out_stall   = 1'b0;
  out_word_t out_data;
  logic      cfg_wr_en   = 1'b0;
  logic      cfg_wr_data = 1'b0;

  qname_board board;
  int         idle_cycles   = 0;
  int         bytes_sent    = 0;
  bit         in_calm       = 1'b0;
  bit         out_calm      = 1'b0;
  bit         long_hold_req = 1'b0;

  dns_query_name_expander #(.MAX_MESSAGE(MSG_CAP), .MAX_NAME(NAME_CAP)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) board.take_word(in_data);
      if (out_valid && !out_stall) board.match_chunk(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("** dns_query_name_expander: FAILED **");
        $finish;
      end
    end
  end

  initial begin : result_sink
    int wait_n, served;
    served = 0;
    wait (rst_n);
    forever begin
      if (served % 32 == 0) out_calm = ($urandom_range(0, 3) == 0);
      if (long_hold_req) begin
        wait_n = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        wait_n = out_calm ? 0 : $urandom_range(0, 8);
      end
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      served++;
    end
  end

  task automatic push_byte(byte unsigned b, bit last);
    in_word_t w;
    int gap;
    w.msg_byte = b;
    w.last_byte = last;
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (bytes_sent % 32 == 0) in_calm = ($urandom_range(0, 3) == 0);
    bytes_sent++;
    gap = in_calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_message(bytes_t m);
    int i;
    for (i = 0; i < m.size(); i++) push_byte(m[i], i == m.size() - 1);
  endtask

  task automatic settle_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.chunks_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_one_question(bit v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.one_question = v;
  endtask

  function automatic bytes_t dns_header(int qd);
    bytes_t m;
    int i;
    for (i = 0; i < HEADER_BYTES; i++) m.push_back($urandom_range(0, 255));
    m[QC_HI_POS] = qd >> 8;
    m[QC_LO_POS] = qd & 'hff;
    return m;
  endfunction

  function automatic byte unsigned pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'h61 + $urandom_range(0, 25);
    if (r < 80) return 8'h30 + $urandom_range(0, 9);
    if (r < 88) return DOT_CHAR;
    if (r < 92) return 8'h00;
    return $urandom_range(0, 255);
  endfunction

  function automatic void add_label(ref bytes_t m, input int len);
    m.push_back(len);
    repeat (len) m.push_back(pick_char());
  endfunction

  function automatic void add_text(ref bytes_t m, input string s);
    int i;
    m.push_back(s.len());
    for (i = 0; i < s.len(); i++) m.push_back(s[i]);
  endfunction

  function automatic void end_question(ref bytes_t m);
    m.push_back(8'h00);
    repeat (4) m.push_back($urandom_range(0, 255));
  endfunction

  function automatic void point_here(ref bytes_t m, input int at);
    m[at]     = 8'hc0 | (m.size() >> 8);
    m[at + 1] = m.size() & 'hff;
  endfunction

  function automatic bytes_t good_message();
    bytes_t m;
    int labels, at, i;
    m = dns_header(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : 1);
    labels = $urandom_range(0, 3);
    for (i = 0; i < labels; i++) add_label(m, $urandom_range(1, 12));
    if ($urandom_range(0, 2) == 0) begin
      at = m.size();
      m.push_back(8'h00);
      m.push_back(8'h00);
      repeat ($urandom_range(0, 6)) m.push_back($urandom_range(0, 255));
      point_here(m, at);
      repeat ($urandom_range(1, 2)) add_label(m, $urandom_range(1, 10));
      m.push_back(8'h00);
    end else begin
      end_question(m);
    end
    return m;
  endfunction

  function automatic bytes_t random_message();
    bytes_t m;
    int k, cut;
    m = good_message();
    k = $urandom_range(0, 99);
    if (k < 70) return m;
    if (k < 78) begin
      cut = $urandom_range(1, m.size());
      while (m.size() > cut) void'(m.pop_back());
    end else if (k < 86) begin
      m[$urandom_range(HEADER_BYTES, m.size() - 1)] = $urandom_range(0, 255);
    end else if (k < 91) begin
      m[HEADER_BYTES] = {($urandom_range(0, 1) ? 2'b01 : 2'b10), 6'($urandom_range(0, 63))};
    end else if (k < 95) begin
      m[HEADER_BYTES]     = 8'hc0 | $urandom_range(0, 63);
      m[HEADER_BYTES + 1] = $urandom_range(0, 255);
      if ($urandom_range(0, 1)) m[HEADER_BYTES + 1] = HEADER_BYTES;
    end else begin
      m.delete();
      repeat ($urandom_range(1, HEADER_BYTES - 1)) m.push_back($urandom_range(0, 255));
    end
    return m;
  endfunction

  task automatic run_directed();
    bytes_t m;
    m = dns_header(1);
    add_text(m, "www"); add_text(m, "example"); add_text(m, "com");
    end_question(m);
    send_message(m);
    m = '{8'hff};
    send_message(m);
    m = dns_header(1);
    void'(m.pop_back());
    send_message(m);
    m = dns_header(1);
    send_message(m);
    m = dns_header(2);
    add_text(m, "host");
    end_question(m);
    send_message(m);
    m = dns_header(1);
    end_question(m);
    send_message(m);
    m = dns_header(1);
    m.push_back(8'h40);
    end_question(m);
    send_message(m);
    m = dns_header(1);
    m.push_back(8'hc0); m.push_back(8'hfe);
    end_question(m);
    send_message(m);
    m = dns_header(1);
    m.push_back(8'hc0); m.push_back(HEADER_BYTES);
    end_question(m);
    send_message(m);
    m = dns_header(1);
    add_text(m, "a.b"); add_text(m, "c");
    end_question(m);
    send_message(m);
    m = dns_header(1);
    m.push_back(5); m.push_back("a"); m.push_back("b"); m.push_back(8'h00);
    m.push_back("c"); m.push_back("d");
    end_question(m);
    send_message(m);
    m = dns_header(1);
    m.push_back(10); m.push_back("a"); m.push_back("b"); m.push_back("c");
    send_message(m);
    m = dns_header(1);
    add_text(m, "abc");
    void'(m.pop_back());
    m.push_back("c");
    send_message(m);
    m = dns_header(1);
    add_text(m, "abcdefgh");
    end_question(m);
    send_message(m);
  endtask

  // receiver holds off while a two-word name and a further message queue up
  task automatic run_pressure();
    bytes_t m;
    m.delete();
    repeat (5) m.push_back($urandom_range(0, 255));
    send_message(m);
    m = dns_header(1);
    add_text(m, "pressure12");
    end_question(m);
    send_message(m);
    m.delete();
    repeat (5) m.push_back($urandom_range(0, 255));
    send_message(m);
  endtask

  task automatic run_random(int min_bytes, int min_msgs);
    bytes_t m;
    int bytes_done, msgs_done;
    bytes_done = 0;
    msgs_done = 0;
    while (bytes_done < min_bytes || msgs_done < min_msgs) begin
      m = random_message();
      send_message(m);
      bytes_done += m.size();
      msgs_done++;
    end
  endtask

  initial begin : stimulus
    bytes_t m;
    board = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    settle_results();
    long_hold_req = 1'b1;
    run_pressure();
    settle_results();
    write_one_question(1'b0);
    m = dns_header(2);
    add_text(m, "host");
    end_question(m);
    send_message(m);
    run_random(24, 1);
    settle_results();
    if (board.mismatches == 0 && board.chunks_due.size() == 0) begin
      $display("** dns_query_name_expander: PASSED **");
    end else begin
      $display("** dns_query_name_expander: FAILED **");
    end
    $finish;
  end

endmodule
